// ----- design/rbma_pkg.sv -----
// Shared types and constants for the read buffer map allocator.
// No dependencies; imported by rbma_cell and read_buffer_map_allocator.
package rbma_pkg;

    localparam int FIELDS_PER_MAP = 8;   // 1..8 fields per map
    localparam int FIELD_W        = 4;
    localparam int MASK_W         = 8;
    localparam int CNT_W          = 4;
    localparam int AMT_W          = 4;
    localparam int IDX_W          = 3;   // addresses a bit of the 8-bit mask

    typedef enum logic [1:0] {
        OP_COUNT_OWNED = 2'd0,
        OP_COUNT_FREE  = 2'd1,
        OP_ALLOC       = 2'd2,
        OP_FREE        = 2'd3
    } t_opcode;

    // Request context handed from cell to cell
    typedef struct packed {
        logic                 valid;
        t_opcode              op;
        logic                 sel;
        logic [FIELD_W-1:0]   owner;
        logic [AMT_W-1:0]     remain;
        logic [CNT_W-1:0]     count;
        logic [MASK_W-1:0]    mask;
    } t_ctx;

endpackage

// ----- design/rbma_cell.sv -----
// One field cell: holds field i of both buffer maps and updates it as a
// request context passes by. Depends on rbma_pkg.
module rbma_cell
    import rbma_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IDX_W-1:0]   i_index,
    input  t_ctx               i_ctx,
    output t_ctx               o_ctx
);

    logic [FIELD_W-1:0] r_field [2];
    t_ctx               r_ctx;

    t_ctx               n_ctx;
    logic [FIELD_W-1:0] n_field;
    logic [FIELD_W-1:0] cur;
    logic               owned;
    logic               avail;
    logic               hit;

    always_comb begin
        cur     = r_field[i_ctx.sel];
        owned   = (cur == i_ctx.owner);
        avail   = !cur[FIELD_W-1];
        n_ctx   = i_ctx;
        n_field = cur;
        hit     = 1'b0;
        if (i_ctx.valid) begin
            unique case (i_ctx.op)
                OP_COUNT_OWNED: begin
                    if (owned) n_ctx.count = i_ctx.count + CNT_W'(1);
                end
                OP_COUNT_FREE: begin
                    if (avail) n_ctx.count = i_ctx.count + CNT_W'(1);
                end
                OP_ALLOC: begin
                    if (avail && i_ctx.remain != '0) begin
                        n_field = i_ctx.owner;
                        hit     = 1'b1;
                    end
                end
                OP_FREE: begin
                    // only the enable bit drops; channel and device stay
                    if (owned && i_ctx.remain != '0) begin
                        n_field = {1'b0, cur[FIELD_W-2:0]};
                        hit     = 1'b1;
                    end
                end
            endcase
        end
        if (hit) begin
            n_ctx.remain = i_ctx.remain - AMT_W'(1);
            n_ctx.mask   = i_ctx.mask | (MASK_W'(1) << i_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field[0] <= '0;
            r_field[1] <= '0;
            r_ctx      <= '0;
        end else begin
            if (hit) r_field[i_ctx.sel] <= n_field;
            r_ctx <= n_ctx;
        end
    end

    assign o_ctx = r_ctx;

endmodule

// ----- design/read_buffer_map_allocator.sv -----
// An accepted word passes the entry register, the chain of field cells and the output register to o_valid.
// The request walks the chain of field cells, one cell per cycle.
// Only one word is in flight at a time: o_stall is high from acceptance until the result is taken;
// a new word is taken the cycle after the result leaves.
// Reset (synchronous, active low) frees every field of both maps and empties the chain.
// Top level of the allocator; depends on rbma_pkg and rbma_cell.
module read_buffer_map_allocator
    import rbma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [3:0]        i_slot_code,
    input  logic [AMT_W-1:0]  i_amount,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_failed,
    output logic [MASK_W-1:0] o_changed_mask
);

    logic              r_busy;
    t_ctx              r_entry;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_count;
    logic              r_failed;
    logic [MASK_W-1:0] r_mask;

    t_ctx              chain [FIELDS_PER_MAP+1];
    logic [FIELDS_PER_MAP:0] chain_valid;
    t_ctx              last;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = i_valid && !r_busy;
    assign out_acc = r_out_valid && !i_stall;
    assign o_stall = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_entry <= '0;
        end else begin
            if (in_acc) r_busy <= 1'b1;
            else if (out_acc) r_busy <= 1'b0;
            r_entry.valid  <= in_acc;
            r_entry.op     <= t_opcode'(i_opcode);
            r_entry.sel    <= i_slot_code[0];
            r_entry.owner  <= {1'b1, i_slot_code[3:1]};
            r_entry.remain <= i_amount;
            r_entry.count  <= '0;
            r_entry.mask   <= '0;
        end
    end

    assign chain[0] = r_entry;

    for (genvar g = 0; g < FIELDS_PER_MAP; g++) begin : g_cell
        rbma_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_ctx   (chain[g]),
            .o_ctx   (chain[g+1])
        );
    end

    for (genvar v = 0; v <= FIELDS_PER_MAP; v++) begin : g_valid
        assign chain_valid[v] = chain[v].valid;
    end

    assign last = chain[FIELDS_PER_MAP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (last.valid) r_out_valid <= 1'b1;
            else if (out_acc) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (last.valid) begin
            r_count  <= last.count;
            r_mask   <= last.mask;
            r_failed <= (last.op == OP_ALLOC || last.op == OP_FREE) && (last.remain != '0);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_count        = r_count;
    assign o_failed       = r_failed;
    assign o_changed_mask = r_mask;

    // at most one request in flight along the chain
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(chain_valid))
        else $error("more than one request in the cell chain");

    a_busy_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain_valid != '0 || r_out_valid) |-> r_busy)
        else $error("request in flight while input is open");

    a_count_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_count != '0) |-> (o_changed_mask == '0 && !o_failed))
        else $error("count result carries alloc/free status");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy && r_entry.valid)
        else $error("accepted word not entered");

endmodule

// ----- dv/testbench.sv -----
// Testbench for read_buffer_map_allocator: directed and random requests with a local map model.
// Depends on rbma_pkg and the allocator RTL; results are checked field by field in order.
module testbench;
    import rbma_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1200;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              failed;
        logic [MASK_W-1:0] changed;
    } t_reply;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_opcode = OP_COUNT_OWNED;
    logic [3:0]        i_slot_code = 4'd0;
    logic [AMT_W-1:0]  i_amount = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [CNT_W-1:0]  o_count;
    logic              o_failed;
    logic [MASK_W-1:0] o_changed_mask;

    logic [31:0] buf_map [2];
    t_reply      pending_replies [$];
    int          n_errors = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;   // suppresses idling on both sides

    read_buffer_map_allocator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_slot_code    (i_slot_code),
        .i_amount       (i_amount),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_count        (o_count),
        .o_failed       (o_failed),
        .o_changed_mask (o_changed_mask)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(0, 99) < 15);
    end

    // Applies one request to the local maps and returns the reply it causes
    function automatic t_reply apply_request(t_opcode op, logic [3:0] slot,
                                             logic [AMT_W-1:0] amount);
        t_reply           r;
        logic             sel;
        logic [3:0]       owner;
        logic [3:0]       fld;
        logic [31:0]      m;
        int               done;
        sel   = slot[0];
        owner = {1'b1, slot[3:1]};
        m     = buf_map[sel];
        r     = '0;
        done  = 0;
        for (int i = 0; i < FIELDS_PER_MAP; i++) begin
            fld = m[4*i +: 4];
            case (op)
                OP_COUNT_OWNED: if (fld == owner) r.count++;
                OP_COUNT_FREE:  if (!fld[3]) r.count++;
                OP_ALLOC: begin
                    if (!fld[3] && done < amount) begin
                        m[4*i +: 4] = owner;
                        r.changed[i] = 1'b1;
                        done++;
                    end
                end
                default: begin
                    if (fld == owner && done < amount) begin
                        m[4*i + 3] = 1'b0;   // channel and device bits stay
                        r.changed[i] = 1'b1;
                        done++;
                    end
                end
            endcase
        end
        if (op == OP_ALLOC || op == OP_FREE) begin
            buf_map[sel] = m;
            r.failed = (done < amount);
        end
        return r;
    endfunction

    task automatic send_word(input t_opcode op, input logic [3:0] slot,
                             input logic [AMT_W-1:0] amount);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_slot_code <= slot;
        i_amount    <= amount;
        do @(posedge i_clk); while (o_stall);
        pending_replies.push_back(apply_request(op, slot, amount));
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_replies.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                want = pending_replies.pop_front();
                if (o_count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_count);
                    n_errors++;
                end
                if (o_failed !== want.failed) begin
                    $error("failed: expected %0d, got %0d", want.failed, o_failed);
                    n_errors++;
                end
                if (o_changed_mask !== want.changed) begin
                    $error("changed_mask: expected %02h, got %02h", want.changed,
                           o_changed_mask);
                    n_errors++;
                end
            end
        end
    end

    // Empty maps, zero amounts, full fill with shortfall, drain with shortfall
    task automatic test_fill_and_drain();
        send_word(OP_COUNT_FREE, 4'd0, 4'd0);
        send_word(OP_COUNT_FREE, 4'd1, 4'd15);
        send_word(OP_COUNT_OWNED, 4'd0, 4'd0);
        send_word(OP_ALLOC, 4'd0, 4'd0);
        send_word(OP_FREE, 4'd0, 4'd0);
        send_word(OP_FREE, 4'd0, 4'd3);       // nothing owned yet
        send_word(OP_ALLOC, 4'd0, 4'd15);     // fills all eight, short by seven
        send_word(OP_COUNT_FREE, 4'd0, 4'd0);
        send_word(OP_COUNT_OWNED, 4'd0, 4'd0);
        send_word(OP_ALLOC, 4'd2, 4'd1);      // map full
        send_word(OP_FREE, 4'd0, 4'd3);
        send_word(OP_FREE, 4'd0, 4'd15);
        send_word(OP_COUNT_FREE, 4'd0, 4'd0);
    endtask

    // Owner must match channel and device exactly; maps are independent
    task automatic test_owner_match();
        send_word(OP_ALLOC, 4'd8, 4'd2);      // virtual channel, device 0
        send_word(OP_ALLOC, 4'd0, 4'd2);
        send_word(OP_ALLOC, 4'd6, 4'd1);
        send_word(OP_ALLOC, 4'd15, 4'd3);     // other map
        send_word(OP_FREE, 4'd0, 4'd15);      // must leave the virtual ones alone
        send_word(OP_COUNT_OWNED, 4'd8, 4'd0);
        send_word(OP_COUNT_OWNED, 4'd6, 4'd0);
        send_word(OP_COUNT_OWNED, 4'd15, 4'd0);
        send_word(OP_COUNT_OWNED, 4'd14, 4'd0);
        send_word(OP_ALLOC, 4'd4, 4'd8);      // reuses freed fields first
        send_word(OP_FREE, 4'd15, 4'd9);
        send_word(OP_COUNT_FREE, 4'd1, 4'd0);
    endtask

    task automatic test_random_traffic();
        t_opcode         op;
        logic [3:0]      slot;
        logic [AMT_W-1:0] amount;
        int              pick;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet = (n >= 500 && n < 800);
            pick = $urandom_range(0, 99);
            if (pick < 35)      op = OP_ALLOC;
            else if (pick < 65) op = OP_FREE;
            else if (pick < 85) op = OP_COUNT_OWNED;
            else                op = OP_COUNT_FREE;
            slot = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < 80) amount = AMT_W'($urandom_range(0, 4));
            else                            amount = AMT_W'($urandom_range(0, 15));
            send_word(op, slot, amount);
        end
        quiet = 1'b0;
    endtask

    initial begin
        buf_map[0] = '0;
        buf_map[1] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_and_drain();
        test_owner_match();
        test_random_traffic();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (FIELDS_PER_MAP + 4) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            $error("%0d results never arrived", pending_replies.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
